// ----- rtl/core/rv32_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_pkg: shared types and constants of the RV32I execute unit
// Operation codes, widths and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package rv32_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned REG_AW = 5;
	localparam int unsigned KIND_W = 6;
	localparam int unsigned DEF_MEM_BYTES = 4096;
	localparam logic [XLEN-1:0] PC_STEP = 32'd4;

	typedef enum logic [KIND_W-1:0] {
		OP_LUI = 6'd0, OP_AUIPC = 6'd1, OP_JAL = 6'd2, OP_JALR = 6'd3,
		OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BLT = 6'd6, OP_BGE = 6'd7,
		OP_BLTU = 6'd8, OP_BGEU = 6'd9, OP_LB = 6'd10, OP_LH = 6'd11,
		OP_LW = 6'd12, OP_LBU = 6'd13, OP_LHU = 6'd14, OP_SB = 6'd15,
		OP_SH = 6'd16, OP_SW = 6'd17, OP_ADDI = 6'd18, OP_SLTI = 6'd19,
		OP_SLTIU = 6'd20, OP_XORI = 6'd21, OP_ORI = 6'd22, OP_ANDI = 6'd23,
		OP_SLLI = 6'd24, OP_SRLI = 6'd25, OP_SRAI = 6'd26, OP_ADD = 6'd27,
		OP_SUB = 6'd28, OP_SLL = 6'd29, OP_SLT = 6'd30, OP_SLTU = 6'd31,
		OP_XOR = 6'd32, OP_SRL = 6'd33, OP_SRA = 6'd34, OP_OR = 6'd35,
		OP_AND = 6'd36
	} op_t;

	// instruction classes found by the front end
	typedef enum logic [2:0] {
		CL_NOP, CL_ALU, CL_JUMP, CL_BRANCH, CL_LOAD, CL_STORE
	} cls_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_EXEC, ST_MEM, ST_WB
	} bstate_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		cls_t              cls;
		logic [REG_AW-1:0] rd;
		logic [REG_AW-1:0] rs1;
		logic [REG_AW-1:0] rs2;
		logic [XLEN-1:0]   imm;
	} instr_t;

	localparam int unsigned IN_DATA_W = 53;
	localparam int unsigned OUT_DATA_W = 72;

	// register write address of configuration register start_pc
	localparam logic [1:0] REG_START_PC = 2'd0;

endpackage

// ----- rtl/core/rv32i_execute_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_execute_unit: RV32I execute unit top level
// channel | direction | payload
// s_axis  | in        | kind, dest_reg, src_reg_a, src_reg_b, immediate
// m_axis  | out       | next_pc, redirected, reg_written, written_index, value
// apb     | in/out    | start_pc at address 0
// An item passes through the back sequencer in steps: register read at the
// take, execute, write-back. Loads add a memory step for the RAM read.
// After reset the data memory is cleared word by word; the back end takes
// no item from the queue then. The front queue holds two items and fills
// while the back end or the output waits.
// ----------------------------------------------------------------------------
module rv32i_execute_unit #(
	parameter int unsigned MEM_BYTES = rv32_pkg::DEF_MEM_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// kind[5:0] dest_reg[10:6] src_reg_a[15:11] src_reg_b[20:16] immediate[52:21]
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// next_pc[31:0] redirected[32] reg_written[33] written_index[38:34]
	// written_value[70:39]
	output logic [71:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rv32_pkg::*;

	logic [XLEN-1:0] start_pc_q;
	logic            q_valid, q_take, busy;
	instr_t          q_head;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_START_PC) ? start_pc_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= '0;
		end else if (psel && penable && pwrite && paddr == REG_START_PC) begin
			start_pc_q <= pwdata;
		end
	end

	rv32_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[IN_DATA_W-1:0]),
		.q_valid(q_valid), .q_take(q_take), .q_head(q_head)
	);

	rv32_back #(.MEM_BYTES(MEM_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .start_pc(start_pc_q),
		.q_valid(q_valid), .q_take(q_take), .q_head(q_head),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .busy(busy)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) |-> !(busy || q_valid))
		else $error("configuration written while busy");
endmodule

// ----- rtl/core/rv32_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rv32_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- rtl/core/rv32_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_front: instruction intake, classification and queue
// Unpacks each transfer, classifies the operation and holds it in a
// two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module rv32_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rv32_pkg::IN_DATA_W-1:0]  in_data,
	output logic                            q_valid,
	input  logic                            q_take,
	output rv32_pkg::instr_t                q_head
);
	import rv32_pkg::*;

	instr_t     ent_q [2];
	logic       rd_ptr_q, wr_ptr_q;
	logic [1:0] cnt_q;
	instr_t     dec;
	logic       push, pop;

	always_comb begin
		dec.kind = in_data[5:0];
		dec.rd   = in_data[10:6];
		dec.rs1  = in_data[15:11];
		dec.rs2  = in_data[20:16];
		dec.imm  = in_data[52:21];
		unique case (in_data[5:0]) inside
			OP_LUI, OP_AUIPC, [OP_ADDI:OP_AND]: dec.cls = CL_ALU;
			OP_JAL, OP_JALR:                    dec.cls = CL_JUMP;
			[OP_BEQ:OP_BGEU]:                   dec.cls = CL_BRANCH;
			[OP_LB:OP_LHU]:                     dec.cls = CL_LOAD;
			[OP_SB:OP_SW]:                      dec.cls = CL_STORE;
			default:                            dec.cls = CL_NOP;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_take;
	assign q_head   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");
endmodule

// ----- rtl/core/rv32_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_back: execute, memory access and write-back
// Sequencer over register file, ALU and byte-lane data memory.
// ----------------------------------------------------------------------------
module rv32_back #(
	parameter int unsigned MEM_BYTES = rv32_pkg::DEF_MEM_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [rv32_pkg::XLEN-1:0]      start_pc,
	input  logic                           q_valid,
	output logic                           q_take,
	input  rv32_pkg::instr_t               q_head,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rv32_pkg::OUT_DATA_W-1:0] out_data,
	output logic                           busy
);
	import rv32_pkg::*;

	localparam int unsigned WORDS = MEM_BYTES / 4;
	localparam int unsigned WAW = $clog2(WORDS);
	localparam int unsigned BAW = $clog2(MEM_BYTES);

	bstate_t    state_q, state_d;
	logic [WAW-1:0] clr_q;
	logic [XLEN-1:0] rf_q [32];
	logic [XLEN-1:0] pc_q;
	instr_t     ins_q;
	logic [XLEN-1:0] a_q, b_q, ea_q;
	logic       ovalid_q;
	logic [OUT_DATA_W-1:0] odata_q;

	// four byte banks, byte interleaved
	logic [3:0]       bwe;
	logic [WAW-1:0]   baddr [4];
	logic [7:0]       bwd   [4];
	logic [7:0]       brd   [4];

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_bank
			rv32_ram #(.WIDTH(8), .DEPTH(WORDS)) u_bank (
				.clk(clk), .we(bwe[g]), .addr(baddr[g]), .wdata(bwd[g]), .rdata(brd[g])
			);
		end
	endgenerate

	logic [XLEN-1:0] a_rd, b_rd;
	assign a_rd = rf_q[q_head.rs1];
	assign b_rd = rf_q[q_head.rs2];

	// byte j of the access lies at ea + j; bank = low two bits
	logic [BAW-1:0] ea_b;
	assign ea_b = ea_q[BAW-1:0];

	always_comb begin
		logic [BAW-1:0] ba;
		logic [1:0]     lane;
		bwe = 4'b0;
		for (int j = 0; j < 4; j++) begin
			baddr[j] = '0;
			bwd[j]   = 8'd0;
		end
		for (int j = 0; j < 4; j++) begin
			ba   = ea_b + BAW'(j);
			lane = ba[1:0];
			baddr[lane] = state_q == ST_CLEAR ? clr_q : ba[BAW-1:2];
			bwd[lane]   = b_q[8*j +: 8];
		end
		if (state_q == ST_CLEAR) begin
			bwe = 4'hF;
			for (int j = 0; j < 4; j++) begin
				baddr[j] = clr_q;
				bwd[j]   = 8'd0;
			end
		end else if (state_q == ST_EXEC && ins_q.cls == CL_STORE) begin
			for (int j = 0; j < 4; j++) begin
				ba = ea_b + BAW'(j);
				if (j == 0 || (j == 1 && ins_q.kind != OP_SB) || (j >= 2 && ins_q.kind == OP_SW))
					bwe[ba[1:0]] = 1'b1;
			end
		end
	end

	// ALU
	logic [XLEN-1:0] opb, alu, lval, wval, npc, pc4;
	logic [4:0] shamt;
	logic taken, wr;
	assign opb   = (ins_q.kind >= OP_ADD) ? b_q : ins_q.imm;
	assign shamt = opb[4:0];
	assign pc4   = pc_q + PC_STEP;

	always_comb begin
		case (ins_q.kind)
			OP_LUI:            alu = ins_q.imm;
			OP_AUIPC:          alu = pc_q + ins_q.imm;
			OP_ADDI, OP_ADD:   alu = a_q + opb;
			OP_SUB:            alu = a_q - b_q;
			OP_SLTI, OP_SLT:   alu = {31'd0, $signed(a_q) < $signed(opb)};
			OP_SLTIU, OP_SLTU: alu = {31'd0, a_q < opb};
			OP_XORI, OP_XOR:   alu = a_q ^ opb;
			OP_ORI, OP_OR:     alu = a_q | opb;
			OP_ANDI, OP_AND:   alu = a_q & opb;
			OP_SLLI, OP_SLL:   alu = a_q << shamt;
			OP_SRLI, OP_SRL:   alu = a_q >> shamt;
			OP_SRAI, OP_SRA:   alu = XLEN'($signed(a_q) >>> shamt);
			default:           alu = pc4;
		endcase
		case (ins_q.kind)
			OP_BEQ:  taken = a_q == b_q;
			OP_BNE:  taken = a_q != b_q;
			OP_BLT:  taken = $signed(a_q) < $signed(b_q);
			OP_BGE:  taken = !($signed(a_q) < $signed(b_q));
			OP_BLTU: taken = a_q < b_q;
			OP_BGEU: taken = a_q >= b_q;
			default: taken = 1'b0;
		endcase
	end

	// gather load bytes from the banks
	always_comb begin
		logic [BAW-1:0] ba;
		logic [XLEN-1:0] raw;
		raw = '0;
		for (int j = 0; j < 4; j++) begin
			ba = ea_b + BAW'(j);
			raw[8*j +: 8] = brd[ba[1:0]];
		end
		case (ins_q.kind)
			OP_LB:   lval = {{24{raw[7]}}, raw[7:0]};
			OP_LH:   lval = {{16{raw[15]}}, raw[15:0]};
			OP_LBU:  lval = {24'd0, raw[7:0]};
			OP_LHU:  lval = {16'd0, raw[15:0]};
			default: lval = raw;
		endcase
	end

	always_comb begin
		wr   = ins_q.cls == CL_ALU || ins_q.cls == CL_JUMP || ins_q.cls == CL_LOAD;
		wval = (ins_q.cls == CL_LOAD) ? lval : alu;
		if (ins_q.kind == OP_JALR)
			npc = {ea_q[XLEN-1:1], 1'b0};
		else if (ins_q.kind == OP_JAL || taken)
			npc = pc_q + ins_q.imm;
		else
			npc = pc4;
	end

	logic wr_eff;
	assign wr_eff = wr && ins_q.rd != '0;

	always_comb begin
		state_d = state_q;
		q_take  = 1'b0;
		unique case (state_q)
			ST_CLEAR: if (clr_q == WAW'(WORDS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				q_take = q_valid && (!ovalid_q || out_ready);
				if (q_take) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = (ins_q.cls == CL_LOAD) ? ST_MEM : ST_WB;
			ST_MEM:  state_d = ST_WB;
			ST_WB:   state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = state_q != ST_IDLE || ovalid_q;
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	always_ff @(posedge clk) begin
		if (q_take) begin
			ins_q <= q_head;
			a_q   <= a_rd;
			b_q   <= b_rd;
			ea_q  <= a_rd + q_head.imm;
		end
		if (state_q == ST_WB) begin
			odata_q <= {1'b0, wr_eff ? wval : 32'd0, wr_eff ? ins_q.rd : 5'd0,
				wr_eff, (ins_q.cls == CL_JUMP) || taken, npc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			pc_q     <= start_pc;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 32; i++) rf_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_WB) begin
				pc_q     <= npc;
				ovalid_q <= 1'b1;
				if (wr_eff) rf_q[ins_q.rd] <= wval;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |=> out_valid)
		else $error("result not posted after write-back");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> (!ovalid_q || out_ready))
		else $error("took item while result register blocked");
	assert property (@(posedge clk) disable iff (!arst_n) rf_q[0] == '0)
		else $error("x0 written");
endmodule

// ----- tb/sv/tb_rv32i_execute_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv32i_execute_unit: self-checking bench for the RV32I execute unit
// Drives pre-decoded instructions on the input stream, keeps a shadow copy
// of registers, PC and data memory, and checks every result in order.
// ----------------------------------------------------------------------------
import rv32_pkg::*;

typedef struct {
	logic [31:0] npc;
	logic        redir;
	logic        wr;
	logic [4:0]  widx;
	logic [31:0] wval;
} exec_result_t;

class exec_scoreboard;
	logic [31:0] regs [32];
	logic [31:0] pc;
	logic [7:0]  mem [DEF_MEM_BYTES];
	exec_result_t pending [$];
	int errors;
	int checked;

	function void clear(logic [31:0] spc);
		foreach (regs[i]) regs[i] = '0;
		foreach (mem[i]) mem[i] = '0;
		pc = spc;
	endfunction

	function logic [31:0] load(logic [31:0] addr, int n);
		logic [31:0] v;
		v = '0;
		for (int i = 0; i < n; i++)
			v[8*i +: 8] = mem[(addr + i) % DEF_MEM_BYTES];
		return v;
	endfunction

	function void store(logic [31:0] addr, logic [31:0] v, int n);
		for (int i = 0; i < n; i++)
			mem[(addr + i) % DEF_MEM_BYTES] = v[8*i +: 8];
	endfunction

	// predict one instruction and queue its result
	function void note_instr(logic [5:0] kind, logic [4:0] rd, logic [4:0] rs1,
			logic [4:0] rs2, logic [31:0] imm);
		logic [31:0] a, b, ea, npc, val;
		logic wr, redir, taken;
		exec_result_t r;
		a = regs[rs1];
		b = regs[rs2];
		ea = a + imm;
		npc = pc + PC_STEP;
		val = '0;
		wr = 1'b0;
		redir = 1'b0;
		taken = 1'b0;
		case (kind)
			OP_LUI: begin val = imm; wr = 1; end
			OP_AUIPC: begin val = imm + pc; wr = 1; end
			OP_JAL: begin val = pc + PC_STEP; wr = 1; npc = pc + imm; redir = 1; end
			OP_JALR: begin val = pc + PC_STEP; wr = 1; npc = ea & ~32'd1; redir = 1; end
			OP_BEQ: taken = a == b;
			OP_BNE: taken = a != b;
			OP_BLT: taken = $signed(a) < $signed(b);
			OP_BGE: taken = $signed(a) >= $signed(b);
			OP_BLTU: taken = a < b;
			OP_BGEU: taken = a >= b;
			OP_LB: begin val = load(ea, 1); val = {{24{val[7]}}, val[7:0]}; wr = 1; end
			OP_LH: begin val = load(ea, 2); val = {{16{val[15]}}, val[15:0]}; wr = 1; end
			OP_LW: begin val = load(ea, 4); wr = 1; end
			OP_LBU: begin val = load(ea, 1); wr = 1; end
			OP_LHU: begin val = load(ea, 2); wr = 1; end
			OP_SB: store(ea, b, 1);
			OP_SH: store(ea, b, 2);
			OP_SW: store(ea, b, 4);
			OP_ADDI: begin val = a + imm; wr = 1; end
			OP_SLTI: begin val = ($signed(a) < $signed(imm)) ? 1 : 0; wr = 1; end
			OP_SLTIU: begin val = (a < imm) ? 1 : 0; wr = 1; end
			OP_XORI: begin val = a ^ imm; wr = 1; end
			OP_ORI: begin val = a | imm; wr = 1; end
			OP_ANDI: begin val = a & imm; wr = 1; end
			OP_SLLI: begin val = a << imm[4:0]; wr = 1; end
			OP_SRLI: begin val = a >> imm[4:0]; wr = 1; end
			OP_SRAI: begin val = $signed(a) >>> imm[4:0]; wr = 1; end
			OP_ADD: begin val = a + b; wr = 1; end
			OP_SUB: begin val = a - b; wr = 1; end
			OP_SLL: begin val = a << b[4:0]; wr = 1; end
			OP_SLT: begin val = ($signed(a) < $signed(b)) ? 1 : 0; wr = 1; end
			OP_SLTU: begin val = (a < b) ? 1 : 0; wr = 1; end
			OP_XOR: begin val = a ^ b; wr = 1; end
			OP_SRL: begin val = a >> b[4:0]; wr = 1; end
			OP_SRA: begin val = $signed(a) >>> b[4:0]; wr = 1; end
			OP_OR: begin val = a | b; wr = 1; end
			OP_AND: begin val = a & b; wr = 1; end
			default: ;
		endcase
		if (kind >= OP_BEQ && kind <= OP_BGEU && taken) begin
			npc = pc + imm;
			redir = 1;
		end
		if (wr && rd != 0)
			regs[rd] = val;
		else begin
			wr = 0;
			rd = 0;
			val = 0;
		end
		pc = npc;
		r.npc = npc;
		r.redir = redir;
		r.wr = wr;
		r.widx = rd;
		r.wval = val;
		pending.push_back(r);
	endfunction

	function void check_result(logic [71:0] d);
		exec_result_t e;
		checked++;
		if (pending.size() == 0) begin
			$error("result with nothing pending: %h", d);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (d[31:0] !== e.npc) begin
			$error("next_pc exp %h got %h", e.npc, d[31:0]); errors++;
		end
		if (d[32] !== e.redir) begin
			$error("redirected exp %b got %b", e.redir, d[32]); errors++;
		end
		if (d[33] !== e.wr) begin
			$error("reg_written exp %b got %b", e.wr, d[33]); errors++;
		end
		if (d[38:34] !== e.widx) begin
			$error("written_index exp %0d got %0d", e.widx, d[38:34]); errors++;
		end
		if (d[70:39] !== e.wval) begin
			$error("written_value exp %h got %h", e.wval, d[70:39]); errors++;
		end
	endfunction
endclass

module tb_rv32i_execute_unit;
	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	exec_scoreboard sb;
	int sent;
	bit hold_off;

	rv32i_execute_unit uut (.*);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	initial begin
		#200ms;
		$display("CHECK FAILED");
		$finish;
	end

	function int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// output side: random stalls, one long hold-off on request
	always @(negedge clk) begin
		if (hold_off || !arst_n)
			m_axis_tready <= 1'b0;
		else if ($urandom_range(0, 3) == 0)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= 1'b1;
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);

	task automatic apb_write(logic [1:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_instr(logic [5:0] kind, logic [4:0] rd, logic [4:0] rs1,
			logic [4:0] rs2, logic [31:0] imm);
		int g;
		g = gap_len();
		repeat (g) begin
			@(negedge clk);
			s_axis_tvalid <= 0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {3'b0, imm, rs2, rs1, rd, kind};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_instr(kind, rd, rs1, rs2, imm);
		sent++;
	endtask

	task automatic go_idle();
		int n;
		@(negedge clk);
		s_axis_tvalid <= 0;
		n = 0;
		while (sb.pending.size() != 0 && n < 100000) begin
			@(posedge clk); n++;
		end
		repeat (20) @(posedge clk);
	endtask

	// write a new start PC; it only matters at a later reset
	task automatic restart(logic [31:0] spc);
		go_idle();
		apb_write(REG_START_PC, spc);
	endtask

	task automatic rand_instr();
		logic [5:0] k;
		logic [31:0] imm;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 4) k = $urandom_range(37, 63);
		else k = $urandom_range(0, 36);
		case ($urandom_range(0, 4))
			0: imm = $urandom;
			1: imm = $urandom_range(0, 255);
			2: imm = -$urandom_range(0, 255);
			3: imm = {$urandom_range(0,1) ? 20'hFFFFF : 20'h0, 12'($urandom)};
			default: imm = $urandom_range(0, 4200);
		endcase
		// pick the first source register mostly from x0 to x7
		send_instr(k, 5'($urandom), 5'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 7)),
			5'($urandom), imm);
	endtask

	initial begin
		int n;
		sb = new();
		sent = 0;
		hold_off = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		repeat (6) @(negedge clk);
		sb.clear(32'h0000_0000);
		arst_n = 1;
		// directed: extremes, every operation, wrap and misalign cases
		send_instr(OP_LUI, 1, 0, 0, 32'h8000_0000);
		send_instr(OP_ADDI, 2, 0, 0, 32'hFFFF_FFFF);
		send_instr(OP_ADDI, 0, 2, 0, 32'h7FFF_FFFF);
		send_instr(OP_SW, 0, 0, 2, 32'd4094);
		send_instr(OP_LW, 3, 0, 0, 32'd4094);
		send_instr(OP_LB, 4, 0, 0, 32'd4095);
		send_instr(OP_LHU, 5, 1, 0, 32'd1);
		send_instr(OP_SH, 0, 2, 1, 32'd0);
		send_instr(OP_LBU, 6, 2, 0, 32'd0);
		send_instr(OP_LH, 7, 0, 0, 32'd4094);
		send_instr(OP_SB, 0, 0, 2, 32'd5);
		send_instr(OP_SRAI, 8, 1, 0, 32'hFFFF_FFFF);
		send_instr(OP_SRLI, 9, 1, 0, 32'd33);
		send_instr(OP_SLLI, 10, 2, 0, 32'd31);
		send_instr(OP_SRA, 11, 1, 2, 0);
		send_instr(OP_SLT, 12, 1, 2, 0);
		send_instr(OP_SLTU, 13, 1, 2, 0);
		send_instr(OP_SLTI, 14, 1, 0, 32'h7FFF_FFFF);
		send_instr(OP_SLTIU, 15, 2, 0, 32'hFFFF_FFFF);
		send_instr(OP_JALR, 16, 2, 0, 32'd0);
		send_instr(OP_JAL, 17, 0, 0, 32'h8000_0000);
		send_instr(OP_BLT, 0, 1, 2, 32'hFFFF_FFF0);
		send_instr(OP_BGEU, 0, 1, 2, 32'd12);
		send_instr(6'd63, 31, 31, 31, 32'hFFFF_FFFF);
		for (int k = OP_AUIPC; k <= OP_AND; k++)
			send_instr(6'(k), 5'($urandom), 5'($urandom), 5'($urandom), $urandom);
		go_idle();
		// later start PC writes only affect the next reset
		restart(32'h0000_0000);
		// random phase, with a long output stall in the middle
		for (n = 0; n < 1450; n++) begin
			if (n == 700) begin
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			if (n == 1000) restart(32'h8000_0004);
			rand_instr();
		end
		go_idle();
		$display("Ran %0d instructions over all 37 operations plus unused codes;", sent);
		$display("%0d results checked, including a long output stall.", sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
